### src/stb_pkg.sv
// Shared types and constants for the software timer bank.
package stb_pkg;

  // Bank sizes.
  localparam int NUM_FREE_TIMERS = 16;
  localparam int NUM_CTL_TIMERS  = 16;

  // Address widths of the two memories, and the sweep counter width.
  localparam int FREE_AW  = (NUM_FREE_TIMERS > 1) ? $clog2(NUM_FREE_TIMERS) : 1;
  localparam int CTL_AW   = (NUM_CTL_TIMERS > 1) ? $clog2(NUM_CTL_TIMERS) : 1;
  localparam int SWEEP_N  = (NUM_FREE_TIMERS > NUM_CTL_TIMERS) ?
                            NUM_FREE_TIMERS : NUM_CTL_TIMERS;
  localparam int SWEEP_W  = (SWEEP_N > 1) ? $clog2(SWEEP_N) : 1;

  // Field widths.
  localparam int COUNT_W = 16;
  localparam int TICK_W  = 8;
  localparam int INDEX_W = 4;

  // Command codes.
  typedef enum logic [2:0] {
    OP_ADVANCE   = 3'd0,
    OP_READ_FREE = 3'd1,
    OP_CLR_FREE  = 3'd2,
    OP_READ_CTL  = 3'd3,
    OP_START     = 3'd4,
    OP_STOP      = 3'd5,
    OP_PAUSE     = 3'd6,
    OP_RESUME    = 3'd7
  } op_t;

  // Controllable timer states.
  typedef enum logic [1:0] {
    TS_STOPPED = 2'd0,
    TS_RUNNING = 2'd1,
    TS_PAUSED  = 2'd2
  } timer_state_t;

  // Request and result payloads.
  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] timer_index;
    logic [TICK_W-1:0]  tick_count;
  } request_t;

  typedef struct packed {
    logic [COUNT_W-1:0] timer_value;
    logic [1:0]         timer_state;
  } result_t;

  // One entry of the controllable timer memory.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    timer_state_t       st;
  } ctl_entry_t;

  // Access group from the sequencer to the timer store.
  typedef struct packed {
    logic [FREE_AW-1:0] free_raddr;
    logic [CTL_AW-1:0]  ctl_raddr;
    logic               free_we;
    logic [FREE_AW-1:0] free_waddr;
    logic [COUNT_W-1:0] free_wdata;
    logic               ctl_we;
    logic [CTL_AW-1:0]  ctl_waddr;
    ctl_entry_t         ctl_wdata;
  } bank_req_t;

  // Registered read data from the timer store.
  typedef struct packed {
    logic [COUNT_W-1:0] free_data;
    ctl_entry_t         ctl_data;
  } bank_rsp_t;

endpackage

### src/stb_bank.sv
// Timer store: free and controllable timer memories with per-entry valid bits.
module stb_bank (
  input  logic              clk,
  input  logic              rst_n,
  input  stb_pkg::bank_req_t req,
  output stb_pkg::bank_rsp_t rsp
);

  // Memories; entries that were never written read as their reset value.
  logic [stb_pkg::COUNT_W-1:0] free_mem [stb_pkg::NUM_FREE_TIMERS];
  stb_pkg::ctl_entry_t         ctl_mem  [stb_pkg::NUM_CTL_TIMERS];

  logic [stb_pkg::NUM_FREE_TIMERS-1:0] free_vld_r;
  logic [stb_pkg::NUM_CTL_TIMERS-1:0]  ctl_vld_r;
  stb_pkg::bank_rsp_t                  rsp_r;
  stb_pkg::ctl_entry_t                 ctl_zero;

  assign ctl_zero.count = '0;
  assign ctl_zero.st    = stb_pkg::TS_STOPPED;

  // Valid bits, cleared at reset and set on the first write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_vld_r <= '0;
      ctl_vld_r  <= '0;
    end else begin
      if (req.free_we) begin
        free_vld_r[req.free_waddr] <= 1'b1;
      end
      if (req.ctl_we) begin
        ctl_vld_r[req.ctl_waddr] <= 1'b1;
      end
    end
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (req.free_we) begin
      free_mem[req.free_waddr] <= req.free_wdata;
    end
    if (req.ctl_we) begin
      ctl_mem[req.ctl_waddr] <= req.ctl_wdata;
    end
  end

  // Registered reads.
  always_ff @(posedge clk) begin
    if (free_vld_r[req.free_raddr]) begin
      rsp_r.free_data <= free_mem[req.free_raddr];
    end else begin
      rsp_r.free_data <= '0;
    end
    if (ctl_vld_r[req.ctl_raddr]) begin
      rsp_r.ctl_data <= ctl_mem[req.ctl_raddr];
    end else begin
      rsp_r.ctl_data <= ctl_zero;
    end
  end

  assign rsp = rsp_r;

endmodule

### src/software_timer_bank_core.sv
// Top level of the software timer bank: command sequencer and result register.
//
// A bank of free-running 16-bit timers and a bank of 16-bit controllable
// timers, held in two simple dual-port memories with a registered read.
// Every request returns exactly one result. A request that reads or changes
// one timer passes through a memory read, a read-modify-write step and a
// step that loads the result register. An advance with a nonzero tick
// count sweeps both banks through the memory read port, one entry per
// cycle, then passes through a flush step before its result is loaded.
// An advance with a zero tick count goes straight to loading its result.
// The next request is accepted in the cycle after a result is loaded. A
// new request is accepted while an earlier result still waits in the
// output register. No clearing pass follows reset; the store starts ready.
module software_timer_bank_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stb_pkg::request_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output stb_pkg::result_t  out_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_MODIFY = 6'b000100,
    S_SWEEP  = 6'b001000,
    S_FLUSH  = 6'b010000,
    S_DONE   = 6'b100000
  } seq_state_t;

  seq_state_t                   state_r, state_nxt;
  stb_pkg::request_t            cmd_r, cmd_nxt;
  logic [stb_pkg::SWEEP_W-1:0]  cnt_r, cnt_nxt;
  logic                         s1_vld_r, s1_vld_nxt;
  logic [stb_pkg::SWEEP_W-1:0]  s1_addr_r, s1_addr_nxt;
  stb_pkg::result_t             res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  stb_pkg::result_t             out_data_r, out_data_nxt;

  stb_pkg::bank_req_t           bank_req;
  stb_pkg::bank_rsp_t           bank_rsp;

  logic [stb_pkg::COUNT_W-1:0]  ticks_ext;
  logic                         idx_free_ok;
  logic                         idx_ctl_ok;
  logic                         s1_free_ok;
  logic                         s1_ctl_ok;
  stb_pkg::ctl_entry_t          ctl_upd;

  stb_bank u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (bank_req),
    .rsp   (bank_rsp)
  );

  assign ticks_ext   = {{(stb_pkg::COUNT_W - stb_pkg::TICK_W){1'b0}}, cmd_r.tick_count};
  assign idx_free_ok = int'(cmd_r.timer_index) < stb_pkg::NUM_FREE_TIMERS;
  assign idx_ctl_ok  = int'(cmd_r.timer_index) < stb_pkg::NUM_CTL_TIMERS;
  assign s1_free_ok  = int'(s1_addr_r) < stb_pkg::NUM_FREE_TIMERS;
  assign s1_ctl_ok   = int'(s1_addr_r) < stb_pkg::NUM_CTL_TIMERS;

  // Controllable timer update for a single-timer request.
  always_comb begin
    ctl_upd = bank_rsp.ctl_data;
    case (cmd_r.op)
      stb_pkg::OP_START: begin
        if (bank_rsp.ctl_data.st == stb_pkg::TS_STOPPED) begin
          ctl_upd.count = '0;
          ctl_upd.st    = stb_pkg::TS_RUNNING;
        end
      end
      stb_pkg::OP_STOP: begin
        ctl_upd.st = stb_pkg::TS_STOPPED;
      end
      stb_pkg::OP_PAUSE: begin
        if (bank_rsp.ctl_data.st == stb_pkg::TS_RUNNING) begin
          ctl_upd.st = stb_pkg::TS_PAUSED;
        end
      end
      stb_pkg::OP_RESUME: begin
        if (bank_rsp.ctl_data.st == stb_pkg::TS_PAUSED) begin
          ctl_upd.st = stb_pkg::TS_RUNNING;
        end
      end
      default: begin
        ctl_upd = bank_rsp.ctl_data;
      end
    endcase
  end

  // Read addresses: the sweep counter during an advance, else the request index.
  always_comb begin
    bank_req = '0;
    if (state_r == S_SWEEP) begin
      bank_req.free_raddr = stb_pkg::FREE_AW'(cnt_r);
      bank_req.ctl_raddr  = stb_pkg::CTL_AW'(cnt_r);
    end else begin
      bank_req.free_raddr = stb_pkg::FREE_AW'(cmd_r.timer_index);
      bank_req.ctl_raddr  = stb_pkg::CTL_AW'(cmd_r.timer_index);
    end

    // Sweep write stage: entry read in the previous cycle gets the ticks added.
    if (s1_vld_r) begin
      bank_req.free_we          = s1_free_ok;
      bank_req.free_waddr       = stb_pkg::FREE_AW'(s1_addr_r);
      bank_req.free_wdata       = bank_rsp.free_data + ticks_ext;
      bank_req.ctl_we           = s1_ctl_ok &&
                                  (bank_rsp.ctl_data.st == stb_pkg::TS_RUNNING);
      bank_req.ctl_waddr        = stb_pkg::CTL_AW'(s1_addr_r);
      bank_req.ctl_wdata.count  = bank_rsp.ctl_data.count + ticks_ext;
      bank_req.ctl_wdata.st     = stb_pkg::TS_RUNNING;
    end else if (state_r == S_MODIFY) begin
      bank_req.free_waddr = stb_pkg::FREE_AW'(cmd_r.timer_index);
      bank_req.ctl_waddr  = stb_pkg::CTL_AW'(cmd_r.timer_index);
      bank_req.free_wdata = '0;
      bank_req.ctl_wdata  = ctl_upd;
      if (cmd_r.op == stb_pkg::OP_CLR_FREE) begin
        bank_req.free_we = idx_free_ok;
      end
      if (cmd_r.op == stb_pkg::OP_START || cmd_r.op == stb_pkg::OP_STOP ||
          cmd_r.op == stb_pkg::OP_PAUSE || cmd_r.op == stb_pkg::OP_RESUME) begin
        bank_req.ctl_we = idx_ctl_ok;
      end
    end
  end

  // Sequencer and result register.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    s1_vld_nxt    = 1'b0;
    s1_addr_nxt   = s1_addr_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data;
          if (in_data.op != stb_pkg::OP_ADVANCE) begin
            state_nxt = S_READ;
          end else if (in_data.tick_count != '0) begin
            cnt_nxt   = '0;
            state_nxt = S_SWEEP;
          end else begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_READ: begin
        state_nxt = S_MODIFY;
      end
      S_MODIFY: begin
        res_nxt = '0;
        if (cmd_r.op == stb_pkg::OP_READ_FREE) begin
          if (idx_free_ok) begin
            res_nxt.timer_value = bank_rsp.free_data;
          end
        end else if (cmd_r.op == stb_pkg::OP_CLR_FREE) begin
          res_nxt.timer_value = '0;
        end else if (idx_ctl_ok) begin
          res_nxt.timer_value = ctl_upd.count;
          res_nxt.timer_state = ctl_upd.st;
        end
        state_nxt = S_DONE;
      end
      S_SWEEP: begin
        s1_vld_nxt  = 1'b1;
        s1_addr_nxt = cnt_r;
        if (int'(cnt_r) == stb_pkg::SWEEP_N - 1) begin
          state_nxt = S_FLUSH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FLUSH: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cnt_r      <= cnt_nxt;
    s1_addr_r  <= s1_addr_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
